[hdl/krt_pkg.sv]
// Package for the keyed refresh table: request and result structs, command
// and result codes, and the control/status structs between controller and datapath.
// No dependencies.
package krt_pkg;

  // Request command codes
  localparam logic [1:0] CMD_RECORD  = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_RECORD_ACK = 2'd0;
  localparam logic [1:0] KIND_CLEAR_ACK  = 2'd1;
  localparam logic [1:0] KIND_SEND       = 2'd2;
  localparam logic [1:0] KIND_NONE_DUE   = 2'd3;

  // Refresh period after reset, in ms
  localparam logic [31:0] DEFAULT_PERIOD_MS = 32'd10000;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  key_class;
    logic [7:0]  key_group;
    logic [31:0] payload_word;
    logic [31:0] now_ms;
    logic        link_up;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot_index;
    logic        key_hit;
    logic        evicted;
    logic [7:0]  ent_class;
    logic [7:0]  ent_group;
    logic [31:0] out_payload;
    logic        last_of_run;
  } out_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;        // latch request, reset scan state
    logic scan_issue;     // read slot at index, advance index
    logic idx_clear;      // rewind index for the send pass
    logic idx_inc;        // skip a slot in the send pass
    logic commit_record;  // write chosen slot, load record ack
    logic commit_clear;   // free matched slot, load clear ack
    logic load_none;      // load nothing-due result
    logic send_rd;        // read due slot for sending
    logic send_load;      // load send result, drop due bit
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] req_cmd;
    logic       idx_last;
    logic       due_at_idx;
    logic       due_any;
    logic       last_due;
    logic       out_free;
  } ctrl_stat_t;

endpackage

[hdl/keyed_refresh_table.sv]
// keyed_refresh_table: table of keyed entries with record, clear and periodic refresh.
//
// Use: requests enter on in_valid/in_stall with an in_req_t payload (command,
// key, payload word, current ms time, link_up). Results leave on
// out_valid/out_stall as out_rsp_t; last_of_run marks the final result of
// a request. The refresh period is written on cfg_valid/cfg_ready while idle.
// One request is worked on at a time. A record, clear or linked refresh scans
// all SLOTS slots through a single registered read port, one slot a cycle.
// A record or clear result is loaded after the scan and a drain state, once the
// output register is free; the block then goes idle, ready for the next request.
// A linked refresh goes from the drain state to a check state, then skips each
// slot that is not due and reads and sends each due entry; with nothing due it
// loads a nothing-due result. With link_up low that result is loaded without a
// scan; an unused command gives no result and stays idle.
// in_stall is low only in the idle state; the finished result sits in the
// output register, so the next request is taken while it waits.
// When the receiver stalls, out_data holds and the block waits before
// loading the next result. Reset clears all valid bits and sets the
// period to 10000 ms; no clearing pass is needed.
// Depends on krt_pkg, krt_ctrl and krt_datapath.
module keyed_refresh_table #(
  parameter int SLOTS        = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  krt_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output krt_pkg::out_rsp_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  krt_pkg::ctrl_cmd_t  cmd;
  krt_pkg::ctrl_stat_t stat;
  logic                idle;

  // Requests and config are taken only while idle
  assign in_stall  = !idle;
  assign cfg_ready = idle;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_link  (in_data.link_up),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  krt_datapath #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hdl/krt_datapath.sv]
// Datapath of the keyed refresh table: slot memories, valid and due bits,
// scan compare logic, period register and output register. Uses krt_pkg.
module krt_datapath #(
  parameter int SLOTS        = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  krt_pkg::in_req_t    in_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  krt_pkg::ctrl_cmd_t  cmd,
  output krt_pkg::ctrl_stat_t stat,
  input  logic                out_stall,
  output logic                out_valid,
  output krt_pkg::out_rsp_t   out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

  // Slot storage
  logic [7:0]  class_mem [SLOTS];
  logic [7:0]  group_mem [SLOTS];
  pay_t        pay_mem   [SLOTS];
  logic [31:0] stamp_mem [SLOTS];

  krt_pkg::in_req_t  req_r, req_nxt;
  krt_pkg::out_rsp_t out_data_r, out_data_nxt;
  logic [31:0]       period_r, period_nxt;
  idx_t              idx_r, idx_nxt;
  idx_t              rd_idx_r, rd_idx_nxt;
  logic              scan_pend_r, scan_pend_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  due_r, due_nxt;
  logic              hit_found_r, hit_found_nxt;
  logic              free_found_r, free_found_nxt;
  idx_t              hit_slot_r, hit_slot_nxt;
  idx_t              free_slot_r, free_slot_nxt;
  idx_t              min_slot_r, min_slot_nxt;
  logic [31:0]       min_stamp_r, min_stamp_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [7:0]  rd_class_r;
  logic [7:0]  rd_group_r;
  pay_t        rd_pay_r;
  logic [31:0] rd_stamp_r;

  logic             rd_en;
  logic             is_ref;
  logic             ent_valid;
  logic             key_match;
  logic [31:0]      age;
  logic             due_now;
  idx_t             sel_slot;
  pay_t             new_pay;
  logic             stamp_we;
  idx_t             stamp_wa;
  logic             out_free;
  logic [SLOTS-1:0] due_rest;

  // Scan compare on the registered read data
  always_comb begin
    is_ref    = (req_r.command == krt_pkg::CMD_REFRESH);
    ent_valid = valid_r[rd_idx_r];
    key_match = ent_valid && (rd_class_r == req_r.key_class) &&
                (rd_group_r == req_r.key_group);
    age       = req_r.now_ms - rd_stamp_r;
    due_now   = scan_pend_r && is_ref && ent_valid && (age >= period_r);
    new_pay   = pay_t'(req_r.payload_word);
    out_free  = !out_valid_r || !out_stall;
    rd_en     = cmd.scan_issue || cmd.send_rd;
    // Hit, else first free slot, else oldest stamp
    if (hit_found_r) begin
      sel_slot = hit_slot_r;
    end else if (free_found_r) begin
      sel_slot = free_slot_r;
    end else begin
      sel_slot = min_slot_r;
    end
    stamp_we = cmd.commit_record || due_now;
    stamp_wa = cmd.commit_record ? sel_slot : rd_idx_r;
    due_rest = due_r;
    due_rest[idx_r] = 1'b0;
  end

  // Status to controller
  always_comb begin
    stat.req_cmd    = req_r.command;
    stat.idx_last   = (idx_r == idx_t'(SLOTS - 1));
    stat.due_at_idx = due_r[idx_r];
    stat.due_any    = |due_r;
    stat.last_due   = (due_rest == '0);
    stat.out_free   = out_free;
  end

  // Next-state logic
  always_comb begin
    req_nxt        = req_r;
    period_nxt     = period_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    scan_pend_nxt  = cmd.scan_issue;
    valid_nxt      = valid_r;
    due_nxt        = due_r;
    hit_found_nxt  = hit_found_r;
    free_found_nxt = free_found_r;
    hit_slot_nxt   = hit_slot_r;
    free_slot_nxt  = free_slot_r;
    min_slot_nxt   = min_slot_r;
    min_stamp_nxt  = min_stamp_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cfg_we) begin
      period_nxt = cfg_data;
    end

    // Index counter
    if (cmd.capture || cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.scan_issue || cmd.idx_inc || cmd.send_load) begin
      idx_nxt = idx_r + idx_t'(1);
    end
    if (cmd.scan_issue) begin
      rd_idx_nxt = idx_r;
    end

    // New request
    if (cmd.capture) begin
      req_nxt        = in_data;
      hit_found_nxt  = 1'b0;
      free_found_nxt = 1'b0;
      due_nxt        = '0;
    end

    // Record/clear search: first match, first free, oldest stamp
    if (scan_pend_r && !is_ref) begin
      if (key_match && !hit_found_r) begin
        hit_found_nxt = 1'b1;
        hit_slot_nxt  = rd_idx_r;
      end
      if (!ent_valid && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_slot_nxt  = rd_idx_r;
      end
      if ((rd_idx_r == '0) || (rd_stamp_r < min_stamp_r)) begin
        min_slot_nxt  = rd_idx_r;
        min_stamp_nxt = rd_stamp_r;
      end
    end

    // Refresh scan marks due slots
    if (due_now) begin
      due_nxt[rd_idx_r] = 1'b1;
    end
    if (cmd.send_load) begin
      due_nxt[idx_r] = 1'b0;
    end

    // Valid bits
    if (cmd.commit_record) begin
      valid_nxt[sel_slot] = 1'b1;
    end
    if (cmd.commit_clear && hit_found_r) begin
      valid_nxt[hit_slot_r] = 1'b0;
    end

    // Output register
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit_record) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.kind        = krt_pkg::KIND_RECORD_ACK;
      out_data_nxt.slot_index  = 3'(sel_slot);
      out_data_nxt.key_hit     = hit_found_r;
      out_data_nxt.evicted     = !hit_found_r && !free_found_r;
      out_data_nxt.ent_class   = req_r.key_class;
      out_data_nxt.ent_group   = req_r.key_group;
      out_data_nxt.out_payload = 32'(new_pay);
      out_data_nxt.last_of_run = 1'b1;
    end else if (cmd.commit_clear) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.kind        = krt_pkg::KIND_CLEAR_ACK;
      out_data_nxt.slot_index  = hit_found_r ? 3'(hit_slot_r) : 3'd0;
      out_data_nxt.key_hit     = hit_found_r;
      out_data_nxt.evicted     = 1'b0;
      out_data_nxt.ent_class   = req_r.key_class;
      out_data_nxt.ent_group   = req_r.key_group;
      out_data_nxt.out_payload = '0;
      out_data_nxt.last_of_run = 1'b1;
    end else if (cmd.load_none) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt             = '0;
      out_data_nxt.kind        = krt_pkg::KIND_NONE_DUE;
      out_data_nxt.last_of_run = 1'b1;
    end else if (cmd.send_load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.kind        = krt_pkg::KIND_SEND;
      out_data_nxt.slot_index  = 3'(idx_r);
      out_data_nxt.key_hit     = 1'b1;
      out_data_nxt.evicted     = 1'b0;
      out_data_nxt.ent_class   = rd_class_r;
      out_data_nxt.ent_group   = rd_group_r;
      out_data_nxt.out_payload = 32'(rd_pay_r);
      out_data_nxt.last_of_run = (due_rest == '0);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= krt_pkg::DEFAULT_PERIOD_MS;
      idx_r        <= '0;
      scan_pend_r  <= 1'b0;
      valid_r      <= '0;
      due_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      period_r     <= period_nxt;
      idx_r        <= idx_nxt;
      scan_pend_r  <= scan_pend_nxt;
      valid_r      <= valid_nxt;
      due_r        <= due_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    rd_idx_r      <= rd_idx_nxt;
    hit_slot_r    <= hit_slot_nxt;
    free_slot_r   <= free_slot_nxt;
    min_slot_r    <= min_slot_nxt;
    min_stamp_r   <= min_stamp_nxt;
    out_data_r    <= out_data_nxt;
  end

  // Slot memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.commit_record) begin
      class_mem[sel_slot] <= req_r.key_class;
      group_mem[sel_slot] <= req_r.key_group;
      pay_mem[sel_slot]   <= new_pay;
    end
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= req_r.now_ms;
    end
    if (rd_en) begin
      rd_class_r <= class_mem[idx_r];
      rd_group_r <= group_mem[idx_r];
      rd_pay_r   <= pay_mem[idx_r];
      rd_stamp_r <= stamp_mem[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/krt_ctrl.sv]
// Controller of the keyed refresh table: sequences capture, slot scan,
// commit and the refresh send pass. Uses krt_pkg.
module krt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  input  logic                in_link,
  input  krt_pkg::ctrl_stat_t stat,
  output krt_pkg::ctrl_cmd_t  cmd,
  output logic                idle
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN    = 9'b000000010,
    S_DRAIN   = 9'b000000100,
    S_REC     = 9'b000001000,
    S_CLR     = 9'b000010000,
    S_CHECK   = 9'b000100000,
    S_NONE    = 9'b001000000,
    S_SEND_RD = 9'b010000000,
    S_SEND_LD = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_cmd inside {krt_pkg::CMD_RECORD, krt_pkg::CMD_CLEAR}) begin
            state_nxt = S_SCAN;
          end else if (in_cmd == krt_pkg::CMD_REFRESH) begin
            state_nxt = in_link ? S_SCAN : S_NONE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read is evaluated this cycle
        cmd.idx_clear = 1'b1;
        case (stat.req_cmd)
          krt_pkg::CMD_RECORD: state_nxt = S_REC;
          krt_pkg::CMD_CLEAR:  state_nxt = S_CLR;
          default:             state_nxt = S_CHECK;
        endcase
      end
      S_REC: begin
        if (stat.out_free) begin
          cmd.commit_record = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_CLR: begin
        if (stat.out_free) begin
          cmd.commit_clear = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_CHECK: begin
        state_nxt = stat.due_any ? S_SEND_RD : S_NONE;
      end
      S_NONE: begin
        if (stat.out_free) begin
          cmd.load_none = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SEND_RD: begin
        // walk to the next due slot and read it
        if (stat.due_at_idx) begin
          cmd.send_rd = 1'b1;
          state_nxt   = S_SEND_LD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SEND_LD: begin
        if (stat.out_free) begin
          cmd.send_load = 1'b1;
          state_nxt     = stat.last_due ? S_IDLE : S_SEND_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

endmodule
